### sv/sie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sie_pkg;

  localparam logic [31:0] SPARSE_MAGIC   = 32'hED26_FF3A;
  localparam logic [15:0] KIND_RAW       = 16'hCAC1;
  localparam logic [15:0] KIND_FILL      = 16'hCAC2;
  localparam logic [15:0] KIND_DONT_CARE = 16'hCAC3;
  localparam logic [15:0] KIND_CRC32     = 16'hCAC4;
  localparam logic [15:0] FILE_HDR_STD   = 16'd28;
  localparam logic [15:0] CHUNK_HDR_STD  = 16'd12;

  localparam logic OP_WORD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_ERR  = 2'd2
  } sie_status_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] file_word;
  } sie_step_t;

  typedef struct packed {
    logic [31:0] block_index;
    logic [31:0] image_word;
    logic        block_end;
    sie_status_t status;
  } sie_result_t;

  // Round a byte count up to whole 32-bit words.
  function automatic logic [31:0] bytes_to_words(input logic [31:0] b);
    return {2'b00, b[31:2]} + {31'd0, (b[1:0] != 2'b00)};
  endfunction

endpackage

`default_nettype wire

### sv/sparse_image_expander_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sparse image expander: parses a sparse image delivered as 32-bit
// little-endian file words and produces the expanded image words.
// Input channel: in_tuser selects the operation (0 = file word in in_tdata,
// 1 = pull the next generated word for a fill or don't-care chunk).
// Result channel: out_tdata carries image word and block index, out_tlast
// marks the last word of a block, out_tuser gives the status (data, end of
// image, format error). A pull after the last chunk returns one end word;
// after any format error every input word returns an error word.
// Path: an accepted word is held in the input register, processed once the
// result register is free or draining, and its result (if any) is loaded
// into the result register, which drives out_tvalid.
// Throughput: one word per cycle while the receiver does not stall, set by
// the parse-state update between the input register and the result register.
// Reset (rst_n low, synchronous) returns the parser to the file header and
// empties both registers. When the receiver stalls, the result register
// holds its word, the input register holds one more, then in_tready drops.

module sparse_image_expander_unit
  import sie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] file_word
  input  wire logic        in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] image_word, [63:32] block_index
  output logic             out_tlast,  // block_end
  output logic [1:0]       out_tuser   // [1:0] status
);

  logic        in_valid_r;
  sie_step_t   in_step_r;
  logic        out_valid_r;
  sie_result_t out_res_r;
  logic        fire;
  logic        res_valid;
  sie_result_t res;

  // Process the held word whenever the result register is free or draining.
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_step_r <= '{opcode: in_tuser, file_word: in_tdata};
    end
  end

  sie_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (fire),
    .step      (in_step_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load a new result on each processed word; drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.block_index, out_res_r.image_word};
  assign out_tlast  = out_res_r.block_end;
  assign out_tuser  = out_res_r.status;

`ifndef SYNTH
  // Errors are sticky: once an error word is shown, no other status follows.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_ERR) |=> (!out_tvalid || out_tuser == ST_ERR))
    else $error("non-error result after format error");

  // Only data words can close a block.
  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == ST_DATA))
    else $error("block end on non-data result");

  // Input stalls only while a result waits on the receiver.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire

### sv/sie_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sie_core
  import sie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire sie_step_t   step,
  output logic             res_valid,
  output sie_result_t      res
);

  typedef enum logic [3:0] {
    PH_FHDR    = 4'd0,
    PH_FSKIP   = 4'd1,
    PH_CHDR    = 4'd2,
    PH_CSKIP   = 4'd3,
    PH_FILLVAL = 4'd4,
    PH_RAW     = 4'd5,
    PH_GEN     = 4'd6,
    PH_CRCSKIP = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hwc_r, hwc_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] block_bytes_r, block_bytes_nxt;
  logic [15:0] fhb_r, fhb_nxt;
  logic [15:0] chb_r, chb_nxt;
  logic [31:0] chunks_total_r, chunks_total_nxt;
  logic [31:0] chunks_done_r, chunks_done_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] blocks_left_r, blocks_left_nxt;
  logic [29:0] wlib_r, wlib_nxt;
  logic [31:0] fill_r, fill_nxt;
  logic [31:0] bidx_r, bidx_nxt;
  logic        err_r, err_nxt;

  always_comb begin
    logic        do_dispatch;
    logic        do_next;
    logic        start_blk;
    phase_t      start_ph;
    logic        emit;
    logic [31:0] emit_data;
    logic [29:0] wlib_dec;
    logic [31:0] crc_bytes;
    logic        is_end;

    phase_nxt        = phase_r;
    hwc_nxt          = hwc_r;
    skip_nxt         = skip_r;
    block_bytes_nxt  = block_bytes_r;
    fhb_nxt          = fhb_r;
    chb_nxt          = chb_r;
    chunks_total_nxt = chunks_total_r;
    chunks_done_nxt  = chunks_done_r;
    kind_nxt         = kind_r;
    total_nxt        = total_r;
    blocks_left_nxt  = blocks_left_r;
    wlib_nxt         = wlib_r;
    fill_nxt         = fill_r;
    bidx_nxt         = bidx_r;
    err_nxt          = err_r;
    do_dispatch      = 1'b0;
    do_next          = 1'b0;
    start_blk        = 1'b0;
    start_ph         = PH_GEN;
    emit             = 1'b0;
    emit_data        = 32'd0;
    wlib_dec         = 30'd0;
    crc_bytes        = 32'd0;
    is_end           = 1'b0;
    res_valid        = 1'b0;
    res              = '{block_index: 32'd0, image_word: 32'd0, block_end: 1'b0,
                         status: ST_DATA};

    if (step.opcode == OP_PULL) begin
      if (phase_r == PH_GEN) begin
        emit      = 1'b1;
        emit_data = (kind_r == KIND_FILL) ? fill_r : 32'd0;
      end else if (phase_r == PH_DONE) begin
        res_valid  = 1'b1;
        res.status = ST_END;
      end
    end else begin
      unique case (phase_r)
        PH_FHDR: begin
          case (hwc_r)
            3'd0: if (step.file_word != SPARSE_MAGIC) err_nxt = 1'b1;
            3'd2: begin
              fhb_nxt = step.file_word[15:0];
              chb_nxt = step.file_word[31:16];
            end
            3'd3: begin
              block_bytes_nxt = step.file_word;
              if (step.file_word == 32'd0 || step.file_word[1:0] != 2'b00) err_nxt = 1'b1;
            end
            3'd5: chunks_total_nxt = step.file_word;
            default: ;
          endcase
          hwc_nxt = hwc_r + 3'd1;
          if (hwc_r == 3'd6 && !err_nxt) begin
            if (fhb_nxt > FILE_HDR_STD) begin
              skip_nxt  = bytes_to_words({16'd0, fhb_nxt - FILE_HDR_STD});
              phase_nxt = PH_FSKIP;
            end else begin
              do_next = 1'b1;
            end
          end
        end
        PH_FSKIP, PH_CRCSKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_r == 32'd1) do_next = 1'b1;
        end
        PH_CHDR: begin
          if (hwc_r == 3'd0) kind_nxt = step.file_word[15:0];
          else if (hwc_r == 3'd1) blocks_left_nxt = step.file_word;
          else total_nxt = step.file_word;
          hwc_nxt = hwc_r + 3'd1;
          if (hwc_r == 3'd2) begin
            chunks_done_nxt = chunks_done_r + 32'd1;
            if (chb_r > CHUNK_HDR_STD) begin
              skip_nxt  = bytes_to_words({16'd0, chb_r - CHUNK_HDR_STD});
              phase_nxt = PH_CSKIP;
            end else begin
              do_dispatch = 1'b1;
            end
          end
        end
        PH_CSKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_r == 32'd1) do_dispatch = 1'b1;
        end
        PH_FILLVAL: begin
          fill_nxt  = step.file_word;
          start_blk = 1'b1;
          start_ph  = PH_GEN;
        end
        PH_RAW: begin
          emit      = 1'b1;
          emit_data = step.file_word;
        end
        PH_GEN: err_nxt = 1'b1;
        default: ;
      endcase
    end

    // Emit one image word and advance block bookkeeping.
    if (emit) begin
      wlib_dec        = wlib_r - 30'd1;
      is_end          = (wlib_dec == 30'd0);
      wlib_nxt        = wlib_dec;
      res_valid       = 1'b1;
      res.image_word  = emit_data;
      res.block_index = bidx_r;
      res.block_end   = is_end;
      if (is_end) begin
        bidx_nxt        = bidx_r + 32'd1;
        blocks_left_nxt = blocks_left_r - 32'd1;
        if (blocks_left_r == 32'd1) do_next = 1'b1;
        else wlib_nxt = block_bytes_r[31:2];
      end
    end

    // Chunk header complete: route by chunk type.
    if (do_dispatch) begin
      if (kind_nxt == KIND_RAW) begin
        start_blk = 1'b1;
        start_ph  = PH_RAW;
      end else if (kind_nxt == KIND_FILL) begin
        phase_nxt = PH_FILLVAL;
      end else if (kind_nxt == KIND_DONT_CARE) begin
        start_blk = 1'b1;
        start_ph  = PH_GEN;
      end else if (kind_nxt == KIND_CRC32) begin
        crc_bytes       = (total_nxt > {16'd0, chb_nxt}) ? total_nxt - {16'd0, chb_nxt}
                                                         : 32'd0;
        blocks_left_nxt = 32'd0;
        skip_nxt        = bytes_to_words(crc_bytes);
        if (crc_bytes == 32'd0) do_next = 1'b1;
        else phase_nxt = PH_CRCSKIP;
      end else if (blocks_left_nxt != 32'd0) begin
        err_nxt = 1'b1;
      end else begin
        do_next = 1'b1;
      end
    end

    if (start_blk) begin
      if (blocks_left_nxt == 32'd0) begin
        do_next = 1'b1;
      end else begin
        phase_nxt = start_ph;
        wlib_nxt  = block_bytes_nxt[31:2];
      end
    end

    if (do_next) begin
      if (chunks_done_nxt >= chunks_total_nxt) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_CHDR;
        hwc_nxt   = 3'd0;
      end
    end

    if (err_nxt) begin
      res_valid = 1'b1;
      res       = '{block_index: 32'd0, image_word: 32'd0, block_end: 1'b0,
                    status: ST_ERR};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_FHDR;
      hwc_r          <= 3'd0;
      skip_r         <= 32'd0;
      block_bytes_r  <= 32'd0;
      fhb_r          <= 16'd0;
      chb_r          <= 16'd0;
      chunks_total_r <= 32'd0;
      chunks_done_r  <= 32'd0;
      kind_r         <= 16'd0;
      total_r        <= 32'd0;
      blocks_left_r  <= 32'd0;
      wlib_r         <= 30'd0;
      fill_r         <= 32'd0;
      bidx_r         <= 32'd0;
      err_r          <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      hwc_r          <= hwc_nxt;
      skip_r         <= skip_nxt;
      block_bytes_r  <= block_bytes_nxt;
      fhb_r          <= fhb_nxt;
      chb_r          <= chb_nxt;
      chunks_total_r <= chunks_total_nxt;
      chunks_done_r  <= chunks_done_nxt;
      kind_r         <= kind_nxt;
      total_r        <= total_nxt;
      blocks_left_r  <= blocks_left_nxt;
      wlib_r         <= wlib_nxt;
      fill_r         <= fill_nxt;
      bidx_r         <= bidx_nxt;
      err_r          <= err_nxt;
    end
  end

endmodule

`default_nettype wire
